### hw/rtl/dmao_pkg.sv
// shared constants for the dual moving average over-current block
// no dependencies; used by the top level and the testbench
package dmao_pkg;

   localparam int WINDOW_DEPTH  = 8;
   localparam int SAMPLE_WIDTH  = 16;
   localparam int CSR_ADDR_W    = 3;
   localparam int CSR_DATA_W    = 32;

   // register index, taken from paddr above the byte offset
   localparam logic REG_FAN_LIMIT = 1'b0;
   localparam logic REG_AUX_LIMIT = 1'b1;

   localparam logic [SAMPLE_WIDTH-1:0] LIMIT_RESET = '1;

endpackage

### hw/rtl/dmao_ram.sv
// generic single-write, single-read ram with registered read data
// no dependencies
module dmao_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 8,
   parameter int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  logic              clock,
   input  logic              wr_en,
   input  logic [ADDR_W-1:0] wr_addr,
   input  logic [WIDTH-1:0]  wr_data,
   input  logic [ADDR_W-1:0] rd_addr,
   output logic [WIDTH-1:0]  rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

### hw/rtl/dmao_divider.sv
// bit-serial restoring divider, one quotient bit per cycle
// no dependencies; shared by both channels under the top level sequencer
module dmao_divider #(
   parameter int DIVIDEND_W = 19,
   parameter int DIVISOR_W  = 4,
   parameter int QUOT_W     = 16
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  start,
   input  logic [DIVIDEND_W-1:0] dividend,
   input  logic [DIVISOR_W-1:0]  divisor,
   output logic                  done,
   output logic [QUOT_W-1:0]     quotient
);

   localparam int CountW = $clog2(DIVIDEND_W + 1);
   localparam logic [CountW-1:0] LastStep = CountW'(DIVIDEND_W - 1);

   logic                  busy_ff, busy_in;
   logic                  done_ff, done_in;
   logic [CountW-1:0]     count_ff, count_in;
   logic [DIVISOR_W-1:0]  rem_ff, rem_in;
   logic [DIVIDEND_W-1:0] quot_ff, quot_in;
   logic [DIVISOR_W-1:0]  divisor_ff, divisor_in;

   logic [DIVISOR_W:0] shifted;
   logic [DIVISOR_W:0] diff;
   logic               fits;

   always_comb begin
      shifted = {rem_ff, quot_ff[DIVIDEND_W-1]};
      diff    = shifted - {1'b0, divisor_ff};
      fits    = shifted >= {1'b0, divisor_ff};

      busy_in    = busy_ff;
      done_in    = done_ff;
      count_in   = count_ff;
      rem_in     = rem_ff;
      quot_in    = quot_ff;
      divisor_in = divisor_ff;

      if (start) begin
         busy_in    = 1'b1;
         done_in    = 1'b0;
         count_in   = '0;
         rem_in     = '0;
         quot_in    = dividend;
         divisor_in = divisor;
      end else if (busy_ff) begin
         rem_in  = fits ? diff[DIVISOR_W-1:0] : shifted[DIVISOR_W-1:0];
         quot_in = {quot_ff[DIVIDEND_W-2:0], fits};
         count_in = count_ff + 1'b1;
         if (count_ff == LastStep) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff  <= 1'b0;
         done_ff  <= 1'b0;
         count_ff <= '0;
      end else begin
         busy_ff  <= busy_in;
         done_ff  <= done_in;
         count_ff <= count_in;
      end
      rem_ff     <= rem_in;
      quot_ff    <= quot_in;
      divisor_ff <= divisor_in;
   end

   assign done     = done_ff;
   assign quotient = quot_ff[QUOT_W-1:0];

endmodule

### hw/rtl/dual_moving_average_overcurrent.sv
// top level of the dual moving average over-current block
// depends on dmao_pkg, dmao_ram and dmao_divider
//
// usage
// - req channel: one transfer carries a fan and an aux current sample in mA
// - rsp channel: one transfer per request with both window means, the
//   over-current flags and their rising-edge pulses
// - csr port: apb-style, fan limit at byte address 0, aux limit at 4;
//   writes take effect at the access cycle, reads return the limit
// - each request goes from acceptance to the offered response through a
//   ram read state, an update state, the two bit-serial divider runs
//   (fan then aux) and an emit state that loads the output register
// - req_tready is high only while the sequencer is idle, so one request
//   is in flight at a time; the next is taken only once the last one's
//   response has been loaded into the output register
// - the response sits in an output register; the next request is taken
//   while it waits, and the sequencer holds its finished result until the
//   register is free, so a stalled receiver backs up onto req_tready
// - reset clears the window (fill count and totals), the flag history,
//   the response valid and sets both limits to 65535; the ring ram
//   itself is not cleared, entries are only read after being written
module dual_moving_average_overcurrent #(
   parameter int WINDOW_DEPTH = dmao_pkg::WINDOW_DEPTH
) (
   input  logic        clock,
   input  logic        reset,

   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [31:0] req_tdata,   // fan_sample_ma, aux_sample_ma

   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [31:0] rsp_tdata,   // fan_mean_ma, aux_mean_ma
   output logic [3:0]  rsp_tuser,   // fan_over, aux_over, fan_over_rise, aux_over_rise

   input  logic                             csr_psel,
   input  logic                             csr_penable,
   input  logic                             csr_pwrite,
   input  logic [dmao_pkg::CSR_ADDR_W-1:0]  csr_paddr,
   input  logic [dmao_pkg::CSR_DATA_W-1:0]  csr_pwdata,
   output logic [dmao_pkg::CSR_DATA_W-1:0]  csr_prdata,
   output logic                             csr_pready
);

   localparam int SW      = dmao_pkg::SAMPLE_WIDTH;
   localparam int COUNT_W = $clog2(WINDOW_DEPTH + 1);
   localparam int POS_W   = (WINDOW_DEPTH > 1) ? $clog2(WINDOW_DEPTH) : 1;
   localparam int TOTAL_W = SW + COUNT_W;
   localparam logic [COUNT_W-1:0] FULL_COUNT = COUNT_W'(WINDOW_DEPTH);
   localparam logic [POS_W-1:0]   LAST_POS   = POS_W'(WINDOW_DEPTH - 1);

   // sequencer states
   typedef enum logic [5:0] {
      ST_IDLE    = 6'b000001,
      ST_READ    = 6'b000010,
      ST_UPDATE  = 6'b000100,
      ST_DIV_FAN = 6'b001000,
      ST_DIV_AUX = 6'b010000,
      ST_EMIT    = 6'b100000
   } seq_state_type;

   seq_state_type state_ff, state_in;

   // csr registers
   logic [SW-1:0] fan_limit_ff, fan_limit_in;
   logic [SW-1:0] aux_limit_ff, aux_limit_in;
   logic          csr_write;
   logic          csr_index;

   // window state
   logic [POS_W-1:0]   pos_ff, pos_in;
   logic [COUNT_W-1:0] fill_ff, fill_in;
   logic [TOTAL_W-1:0] fan_total_ff, fan_total_in;
   logic [TOTAL_W-1:0] aux_total_ff, aux_total_in;
   logic               fan_prev_ff, fan_prev_in;
   logic               aux_prev_ff, aux_prev_in;

   // captured samples and means
   logic [SW-1:0] fan_sample_ff, fan_sample_in;
   logic [SW-1:0] aux_sample_ff, aux_sample_in;
   logic [SW-1:0] fan_mean_ff, fan_mean_in;

   // output register
   logic          rsp_valid_ff, rsp_valid_in;
   logic [31:0]   rsp_data_ff, rsp_data_in;
   logic [3:0]    rsp_user_ff, rsp_user_in;

   // ring ram and divider hookup
   logic              ram_wr_en;
   logic [2*SW-1:0]   ram_rd_data;
   logic              full;
   logic [SW-1:0]     fan_old;
   logic [SW-1:0]     aux_old;
   logic              div_start;
   logic [TOTAL_W-1:0] div_dividend;
   logic              div_done;
   logic [SW-1:0]     div_quotient;
   logic              fan_over;
   logic              aux_over;
   logic              out_free;

   // ring of both channels side by side: fan in the low half
   dmao_ram #(
      .WIDTH (2 * SW),
      .DEPTH (WINDOW_DEPTH),
      .ADDR_W(POS_W)
   ) u_ring (
      .clock  (clock),
      .wr_en  (ram_wr_en),
      .wr_addr(pos_ff),
      .wr_data({aux_sample_ff, fan_sample_ff}),
      .rd_addr(pos_ff),
      .rd_data(ram_rd_data)
   );

   // one divider, used for the fan mean and then the aux mean
   dmao_divider #(
      .DIVIDEND_W(TOTAL_W),
      .DIVISOR_W (COUNT_W),
      .QUOT_W    (SW)
   ) u_divider (
      .clock   (clock),
      .reset   (reset),
      .start   (div_start),
      .dividend(div_dividend),
      .divisor (fill_in),
      .done    (div_done),
      .quotient(div_quotient)
   );

   // csr access, pready always high
   assign csr_pready = 1'b1;
   assign csr_write  = csr_psel & csr_penable & csr_pwrite;
   assign csr_index  = csr_paddr[2];

   always_comb begin
      case (csr_index)
         dmao_pkg::REG_FAN_LIMIT: csr_prdata = {{(dmao_pkg::CSR_DATA_W - SW){1'b0}}, fan_limit_ff};
         dmao_pkg::REG_AUX_LIMIT: csr_prdata = {{(dmao_pkg::CSR_DATA_W - SW){1'b0}}, aux_limit_ff};
         default:                 csr_prdata = '0;
      endcase
   end

   always_comb begin
      fan_limit_in = fan_limit_ff;
      aux_limit_in = aux_limit_ff;
      if (csr_write) begin
         case (csr_index)
            dmao_pkg::REG_FAN_LIMIT: fan_limit_in = csr_pwdata[SW-1:0];
            dmao_pkg::REG_AUX_LIMIT: aux_limit_in = csr_pwdata[SW-1:0];
            default: ;
         endcase
      end
   end

   // the old ring entry only counts once the window is full
   assign full     = (fill_ff == FULL_COUNT);
   assign fan_old  = full ? ram_rd_data[SW-1:0]    : '0;
   assign aux_old  = full ? ram_rd_data[2*SW-1:SW] : '0;
   assign out_free = !rsp_valid_ff || rsp_tready;
   assign fan_over = fan_mean_ff  >= fan_limit_ff;
   assign aux_over = div_quotient >= aux_limit_ff;

   assign req_tready = (state_ff == ST_IDLE);

   always_comb begin
      state_in      = state_ff;
      pos_in        = pos_ff;
      fill_in       = fill_ff;
      fan_total_in  = fan_total_ff;
      aux_total_in  = aux_total_ff;
      fan_prev_in   = fan_prev_ff;
      aux_prev_in   = aux_prev_ff;
      fan_sample_in = fan_sample_ff;
      aux_sample_in = aux_sample_ff;
      fan_mean_in   = fan_mean_ff;
      rsp_valid_in  = rsp_valid_ff;
      rsp_data_in   = rsp_data_ff;
      rsp_user_in   = rsp_user_ff;
      ram_wr_en     = 1'b0;
      div_start     = 1'b0;
      div_dividend  = aux_total_ff;

      // the receiver takes the held response
      if (rsp_valid_ff && rsp_tready) begin
         rsp_valid_in = 1'b0;
      end

      case (state_ff)
         ST_IDLE: begin
            if (req_tvalid) begin
               fan_sample_in = req_tdata[SW-1:0];
               aux_sample_in = req_tdata[2*SW-1:SW];
               state_in      = ST_READ;
            end
         end
         ST_READ: begin
            // ram read of the slot about to be overwritten is in flight
            state_in = ST_UPDATE;
         end
         ST_UPDATE: begin
            fan_total_in = fan_total_ff - TOTAL_W'(fan_old) + TOTAL_W'(fan_sample_ff);
            aux_total_in = aux_total_ff - TOTAL_W'(aux_old) + TOTAL_W'(aux_sample_ff);
            if (!full) begin
               fill_in = fill_ff + 1'b1;
            end
            pos_in       = (pos_ff == LAST_POS) ? '0 : pos_ff + 1'b1;
            ram_wr_en    = 1'b1;
            div_start    = 1'b1;
            div_dividend = fan_total_in;
            state_in     = ST_DIV_FAN;
         end
         ST_DIV_FAN: begin
            if (div_done) begin
               fan_mean_in  = div_quotient;
               div_start    = 1'b1;
               div_dividend = aux_total_ff;
               state_in     = ST_DIV_AUX;
            end
         end
         ST_DIV_AUX: begin
            if (div_done) begin
               state_in = ST_EMIT;
            end
         end
         ST_EMIT: begin
            // aux quotient stays in the divider until the next start
            if (out_free) begin
               rsp_valid_in = 1'b1;
               rsp_data_in  = {div_quotient, fan_mean_ff};
               rsp_user_in  = {aux_over & ~aux_prev_ff, fan_over & ~fan_prev_ff,
                               aux_over, fan_over};
               fan_prev_in  = fan_over;
               aux_prev_in  = aux_over;
               state_in     = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         fan_limit_ff <= dmao_pkg::LIMIT_RESET;
         aux_limit_ff <= dmao_pkg::LIMIT_RESET;
         pos_ff       <= '0;
         fill_ff      <= '0;
         fan_total_ff <= '0;
         aux_total_ff <= '0;
         fan_prev_ff  <= 1'b0;
         aux_prev_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         fan_limit_ff <= fan_limit_in;
         aux_limit_ff <= aux_limit_in;
         pos_ff       <= pos_in;
         fill_ff      <= fill_in;
         fan_total_ff <= fan_total_in;
         aux_total_ff <= aux_total_in;
         fan_prev_ff  <= fan_prev_in;
         aux_prev_ff  <= aux_prev_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      fan_sample_ff <= fan_sample_in;
      aux_sample_ff <= aux_sample_in;
      fan_mean_ff   <= fan_mean_in;
      rsp_data_ff   <= rsp_data_in;
      rsp_user_ff   <= rsp_user_in;
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;
   assign rsp_tuser  = rsp_user_ff;

endmodule

### dv/dual_moving_average_overcurrent_test.sv
// self-checking testbench for the dual moving average over-current block
// holds its own window model and checks every response against it
// depends on dmao_pkg and the dual_moving_average_overcurrent rtl
module dual_moving_average_overcurrent_test;

   localparam int RING_DEPTH   = dmao_pkg::WINDOW_DEPTH;
   // watchdog limit, well above a request and the longest receiver hold
   localparam int IDLE_LIMIT   = 3000;
   localparam int DRAIN_CYCLES = 60;
   localparam int LONG_HOLD    = 400;
   localparam int PHASE_ITEMS  = 175;

   // one expected response, fields as the block reports them
   typedef struct {
      logic [15:0] fan_mean;
      logic [15:0] aux_mean;
      logic        fan_over;
      logic        aux_over;
      logic        fan_rise;
      logic        aux_rise;
   } window_result_type;

   logic        clock;
   logic        reset;

   logic        req_tvalid;
   logic        req_tready;
   logic [31:0] req_tdata;    // fan_sample_ma, aux_sample_ma

   logic        rsp_tvalid;
   logic        rsp_tready;
   logic [31:0] rsp_tdata;    // fan_mean_ma, aux_mean_ma
   logic [3:0]  rsp_tuser;    // fan_over, aux_over, fan_over_rise, aux_over_rise

   logic                            csr_psel;
   logic                            csr_penable;
   logic                            csr_pwrite;
   logic [dmao_pkg::CSR_ADDR_W-1:0] csr_paddr;
   logic [dmao_pkg::CSR_DATA_W-1:0] csr_pwdata;
   logic [dmao_pkg::CSR_DATA_W-1:0] csr_prdata;
   logic                            csr_pready;

   // window model: ring, slot, fill level, running sums and flag history
   logic [15:0] fan_ring [RING_DEPTH];
   logic [15:0] aux_ring [RING_DEPTH];
   logic [2:0]  ring_slot;
   logic [3:0]  ring_fill;
   logic [18:0] fan_sum;
   logic [18:0] aux_sum;
   logic        fan_over_last;
   logic        aux_over_last;
   logic [15:0] fan_limit;
   logic [15:0] aux_limit;

   window_result_type pending_results[$];

   // receiver control, shared between the tests and the stall process
   bit rx_always_ready;
   bit long_hold_req;

   int fail_count;
   int samples_sent;
   int results_checked;
   int limit_writes;
   int fan_rises_seen;
   int aux_rises_seen;
   int idle_cycles;

   dual_moving_average_overcurrent DUT (
      .clock       (clock),
      .reset       (reset),
      .req_tvalid  (req_tvalid),
      .req_tready  (req_tready),
      .req_tdata   (req_tdata),
      .rsp_tvalid  (rsp_tvalid),
      .rsp_tready  (rsp_tready),
      .rsp_tdata   (rsp_tdata),
      .rsp_tuser   (rsp_tuser),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready)
   );

   initial begin
      clock = 1'b0;
      forever #1 clock = ~clock;
   end

   // ------------------------------------------------------------------
   // window model
   // ------------------------------------------------------------------

   // state after reset; ring contents never matter as entries are only
   // read back once written
   function automatic void clear_window_model();
      for (int i = 0; i < RING_DEPTH; i++) begin
         fan_ring[i] = '0;
         aux_ring[i] = '0;
      end
      ring_slot     = '0;
      ring_fill     = '0;
      fan_sum       = '0;
      aux_sum       = '0;
      fan_over_last = 1'b0;
      aux_over_last = 1'b0;
      fan_limit     = dmao_pkg::LIMIT_RESET;
      aux_limit     = dmao_pkg::LIMIT_RESET;
   endfunction

   // push one sample pair into the window and queue the response it causes
   function automatic void predict_window(input logic [15:0] fan_s,
                                          input logic [15:0] aux_s);
      window_result_type r;
      logic              was_full;
      was_full = (ring_fill >= RING_DEPTH);
      // once full, the oldest sample drops out of the running sum
      if (was_full) begin
         fan_sum = fan_sum - fan_ring[ring_slot];
         aux_sum = aux_sum - aux_ring[ring_slot];
      end
      fan_ring[ring_slot] = fan_s;
      aux_ring[ring_slot] = aux_s;
      fan_sum = fan_sum + fan_s;
      aux_sum = aux_sum + aux_s;
      if (!was_full)
         ring_fill = ring_fill + 1'b1;
      ring_slot = (ring_slot == RING_DEPTH - 1) ? '0 : ring_slot + 1'b1;
      // divisor is the fill level, never zero since the push comes first
      r.fan_mean = 16'(32'(fan_sum) / 32'(ring_fill));
      r.aux_mean = 16'(32'(aux_sum) / 32'(ring_fill));
      r.fan_over = (r.fan_mean >= fan_limit);
      r.aux_over = (r.aux_mean >= aux_limit);
      r.fan_rise = r.fan_over && !fan_over_last;
      r.aux_rise = r.aux_over && !aux_over_last;
      fan_over_last = r.fan_over;
      aux_over_last = r.aux_over;
      pending_results.push_back(r);
   endfunction

   // mostly samples near the channel limit so the flags keep toggling,
   // with uniform values and both extremes mixed in
   function automatic logic [15:0] pick_sample(input logic [15:0] limit);
      int near;
      case ($urandom_range(0, 9))
         0, 1, 2: return 16'($urandom);
         9:       return $urandom_range(0, 1) ? 16'hFFFF : 16'h0000;
         default: begin
            near = int'(limit) + int'($urandom_range(0, 600)) - 300;
            if (near < 0)
               near = 0;
            if (near > 65535)
               near = 65535;
            return 16'(near);
         end
      endcase
   endfunction

   // ------------------------------------------------------------------
   // sender side
   // ------------------------------------------------------------------

   // offer one sample pair and wait for the transfer; valid stays high so
   // a following call continues the burst without a bubble
   task automatic send_sample(input logic [15:0] fan_s, input logic [15:0] aux_s);
      @(negedge clock);
      req_tvalid = 1'b1;
      req_tdata  = {aux_s, fan_s};
      do @(posedge clock); while (!req_tready);
      predict_window(fan_s, aux_s);
      samples_sent++;
   endtask

   // drop valid and stay quiet for a number of cycles
   task automatic pause_sender(input int cycles);
      @(negedge clock);
      req_tvalid = 1'b0;
      repeat (cycles) @(negedge clock);
   endtask

   // random samples in bursts of random length, optionally with random
   // gaps so that requests land on any phase of the request sequence
   task automatic send_random_items(input int count, input bit with_gaps);
      int left;
      int burst;
      left = count;
      while (left > 0) begin
         burst = with_gaps ? int'($urandom_range(1, 12)) : left;
         if (burst > left)
            burst = left;
         repeat (burst) send_sample(pick_sample(fan_limit), pick_sample(aux_limit));
         left -= burst;
         if (with_gaps)
            pause_sender($urandom_range(0, 1) ? $urandom_range(0, 60) : $urandom_range(0, 3));
      end
      pause_sender(0);
   endtask

   // every response in, so the block has nothing in flight
   task automatic wait_idle();
      while (pending_results.size() != 0) @(posedge clock);
      @(negedge clock);
   endtask

   // ------------------------------------------------------------------
   // register access
   // ------------------------------------------------------------------

   task automatic csr_write(input logic reg_sel, input logic [15:0] value);
      @(negedge clock);
      csr_psel    = 1'b1;
      csr_penable = 1'b0;
      csr_pwrite  = 1'b1;
      csr_paddr   = {reg_sel, 2'b00};
      csr_pwdata  = 32'(value);
      @(negedge clock);
      csr_penable = 1'b1;
      do @(posedge clock); while (!csr_pready);
      if (reg_sel == dmao_pkg::REG_FAN_LIMIT)
         fan_limit = value;
      else
         aux_limit = value;
      limit_writes++;
      @(negedge clock);
      csr_psel    = 1'b0;
      csr_penable = 1'b0;
      csr_pwrite  = 1'b0;
   endtask

   task automatic csr_read_check(input logic reg_sel, input logic [15:0] want);
      @(negedge clock);
      csr_psel    = 1'b1;
      csr_penable = 1'b0;
      csr_pwrite  = 1'b0;
      csr_paddr   = {reg_sel, 2'b00};
      @(negedge clock);
      csr_penable = 1'b1;
      do @(posedge clock); while (!csr_pready);
      if (csr_prdata !== 32'(want)) begin
         $display("%0t: limit readback at %0d, expected %0d, got %0d",
                  $time, csr_paddr, want, csr_prdata);
         fail_count++;
      end
      @(negedge clock);
      csr_psel    = 1'b0;
      csr_penable = 1'b0;
   endtask

   // new limits only once the block has gone quiet
   task automatic set_limits(input logic [15:0] fan_lim, input logic [15:0] aux_lim);
      wait_idle();
      csr_write(dmao_pkg::REG_FAN_LIMIT, fan_lim);
      csr_write(dmao_pkg::REG_AUX_LIMIT, aux_lim);
      csr_read_check(dmao_pkg::REG_FAN_LIMIT, fan_lim);
      csr_read_check(dmao_pkg::REG_AUX_LIMIT, aux_lim);
   endtask

   // ------------------------------------------------------------------
   // tests
   // ------------------------------------------------------------------

   task automatic check_reset_limits();
      csr_read_check(dmao_pkg::REG_FAN_LIMIT, dmao_pkg::LIMIT_RESET);
      csr_read_check(dmao_pkg::REG_AUX_LIMIT, dmao_pkg::LIMIT_RESET);
   endtask

   task automatic run_directed_windows();
      // window fill under the reset limits: a full-scale fan mean trips
      // the flag only because it equals 65535 exactly
      repeat (RING_DEPTH) send_sample(16'hFFFF, 16'h0000);
      // first wrap, the oldest samples leave the window
      send_sample(16'h0000, 16'hFFFF);
      send_sample(16'hFFFE, 16'hFFFF);
      pause_sender(0);
      // zero limits: both flags set whatever the mean, both rise here
      set_limits(16'h0000, 16'h0000);
      send_sample(16'hAAAA, 16'h5555);
      send_sample(16'h5555, 16'hAAAA);
      send_sample(16'h0000, 16'h0000);
      pause_sender(0);
      // mid-scale limits: means fall below, then climb back over
      set_limits(16'd30000, 16'd30000);
      repeat (4) send_sample(16'h0000, 16'h0000);
      repeat (4) send_sample(16'hFFFF, 16'hFFFF);
      pause_sender(0);
   endtask

   task automatic run_random_limits();
      logic [15:0] fan_lim;
      logic [15:0] aux_lim;
      for (int phase = 0; phase < 8; phase++) begin
         case (phase)
            0: begin fan_lim = 16'hFFFF; aux_lim = 16'hFFFF; end
            1: begin fan_lim = 16'h0000; aux_lim = 16'h0000; end
            2: begin fan_lim = 16'h0000; aux_lim = 16'hFFFF; end
            3: begin fan_lim = 16'hFFFF; aux_lim = 16'h0000; end
            4: begin fan_lim = 16'($urandom_range(1, 100)); aux_lim = 16'($urandom); end
            default: begin fan_lim = 16'($urandom); aux_lim = 16'($urandom); end
         endcase
         set_limits(fan_lim, aux_lim);
         send_random_items(PHASE_ITEMS, 1'b1);
      end
   endtask

   // back-to-back requests into an always-ready receiver
   task automatic run_full_rate();
      wait_idle();
      rx_always_ready = 1'b1;
      send_random_items(100, 1'b0);
      wait_idle();
      rx_always_ready = 1'b0;
   endtask

   // receiver holds off while the sender keeps offering, so the output
   // register and the sequencer fill and req_tready drops; then the sender
   // waits for every response before anything else happens
   task automatic run_receiver_backpressure();
      wait_idle();
      long_hold_req = 1'b1;
      send_random_items(12, 1'b0);
      wait_idle();
   endtask

   // ------------------------------------------------------------------
   // receiver stall pattern
   // ------------------------------------------------------------------

   // runs of ready and stall of random length, a long hold on request,
   // or plain always-ready for the full-rate stretch
   initial begin : rsp_stall_pattern
      int run_left;
      int hold_left;
      bit ready_now;
      rsp_tready = 1'b0;
      run_left   = 0;
      hold_left  = 0;
      ready_now  = 1'b1;
      forever begin
         @(negedge clock);
         if (long_hold_req) begin
            hold_left     = LONG_HOLD;
            long_hold_req = 1'b0;
         end
         if (hold_left > 0) begin
            hold_left--;
            rsp_tready = 1'b0;
         end else if (rx_always_ready) begin
            rsp_tready = 1'b1;
         end else begin
            if (run_left == 0) begin
               ready_now = ($urandom_range(0, 2) != 0);
               run_left  = ready_now ? $urandom_range(1, 10) : $urandom_range(1, 40);
            end
            run_left--;
            rsp_tready = ready_now;
         end
      end
   end

   // ------------------------------------------------------------------
   // response check
   // ------------------------------------------------------------------

   function automatic void check_field(input string name, input logic [15:0] want,
                                       input logic [15:0] got);
      if (got !== want) begin
         $display("%0t: %s mismatch, expected %0d, got %0d", $time, name, want, got);
         fail_count++;
      end
   endfunction

   // each response transfer against the oldest outstanding prediction
   always @(posedge clock) begin : result_check
      window_result_type want;
      if (!reset && rsp_tvalid && rsp_tready) begin
         if (pending_results.size() == 0) begin
            $display("%0t: response with none outstanding, expected nothing, %s %h %s %h",
                     $time, "got tdata", rsp_tdata, "tuser", rsp_tuser);
            fail_count++;
         end else begin
            want = pending_results.pop_front();
            check_field("fan_mean_ma",   want.fan_mean, rsp_tdata[15:0]);
            check_field("aux_mean_ma",   want.aux_mean, rsp_tdata[31:16]);
            check_field("fan_over",      16'(want.fan_over), 16'(rsp_tuser[0]));
            check_field("aux_over",      16'(want.aux_over), 16'(rsp_tuser[1]));
            check_field("fan_over_rise", 16'(want.fan_rise), 16'(rsp_tuser[2]));
            check_field("aux_over_rise", 16'(want.aux_rise), 16'(rsp_tuser[3]));
            results_checked++;
         end
         if (rsp_tuser[2] === 1'b1)
            fan_rises_seen++;
         if (rsp_tuser[3] === 1'b1)
            aux_rises_seen++;
      end
   end

   // watchdog: any transfer on any port restarts the count
   always @(posedge clock) begin
      if (reset || (req_tvalid && req_tready) || (rsp_tvalid && rsp_tready) ||
          (csr_psel && csr_penable && csr_pready)) begin
         idle_cycles <= 0;
      end else if (idle_cycles >= IDLE_LIMIT) begin
         $display("%0t: no transfer for %0d cycles, %0d responses outstanding",
                  $time, idle_cycles, pending_results.size());
         $display("dual_moving_average_overcurrent regression: fail");
         $finish;
      end else begin
         idle_cycles <= idle_cycles + 1;
      end
   end

   // ------------------------------------------------------------------
   // sequence of tests
   // ------------------------------------------------------------------

   initial begin
      reset           = 1'b1;
      req_tvalid      = 1'b0;
      req_tdata       = '0;
      csr_psel        = 1'b0;
      csr_penable     = 1'b0;
      csr_pwrite      = 1'b0;
      csr_paddr       = '0;
      csr_pwdata      = '0;
      rx_always_ready = 1'b0;
      long_hold_req   = 1'b0;
      fail_count      = 0;
      samples_sent    = 0;
      results_checked = 0;
      limit_writes    = 0;
      fan_rises_seen  = 0;
      aux_rises_seen  = 0;
      idle_cycles     = 0;
      clear_window_model();

      // single synchronous reset at the start
      repeat (6) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      check_reset_limits();
      run_directed_windows();
      run_random_limits();
      run_full_rate();
      run_receiver_backpressure();

      // let the block settle past its own latency before closing
      wait_idle();
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (pending_results.size() != 0) begin
         $display("%0t: %0d responses never arrived, expected 0 outstanding, got %0d",
                  $time, pending_results.size(), pending_results.size());
         fail_count++;
      end

      $display("covered %0d sample transfers and %0d checked responses over %0d limit writes",
               samples_sent, results_checked, limit_writes);
      $display("window fill and wrap, zero and full-scale limits, %0d fan and %0d aux flag rises",
               fan_rises_seen, aux_rises_seen);
      if (fail_count == 0) begin
         $display("dual_moving_average_overcurrent regression: pass");
      end else begin
         $display("dual_moving_average_overcurrent regression: fail");
      end
      $finish;
   end

endmodule
